// ----- hdl/sha_pkg.sv -----
`timescale 1ns / 1ps
package sha_pkg;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned COUNT_W = 61;

	typedef logic [WORD_W-1:0] word_t;

	// control from the sequencer to the schedule memory
	typedef struct packed {
		logic       we;
		logic [3:0] waddr;
		word_t      wdata;
		logic [3:0] raddr;
	} wmem_req_t;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction
endpackage

// ----- hdl/sha_wmem.sv -----
`timescale 1ns / 1ps
// 16-entry message schedule, one write and one registered read a cycle
module sha_wmem (
	input  logic              clk,
	input  sha_pkg::wmem_req_t req,
	output sha_pkg::word_t    rdata
);
	import sha_pkg::*;

	word_t mem [16];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

// ----- hdl/sha_round.sv -----
`timescale 1ns / 1ps
// working variables and one compression round a cycle while step is high; adds into chain on finish
module sha_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           step,
	input  logic [5:0]     rnd,
	input  sha_pkg::word_t w,
	input  logic           finish,
	input  logic           reinit,
	input  logic [2:0]     rd_idx,
	output sha_pkg::word_t rd_word
);
	import sha_pkg::*;

	word_t chain_q [8];
	word_t v_q [8];
	word_t t1, t2, s0, s1, ch, mj;

	always_comb begin
		s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + ROUND_K[rnd] + w;
		s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + mj;
	end

	assign rd_word = chain_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_HASH[i];
		end else if (reinit) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_HASH[i];
		end else if (finish) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
		end else if (step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end
endmodule

// ----- hdl/sha256_message_hasher.sv -----
`timescale 1ns / 1ps
// SHA-256 hasher, at most one message byte per input request.
// Input s_axis: tdata = data_byte; tuser[0] = byte_present, tuser[1] = message_end.
// Output m_axis: tdata = digest_word; tuser[2:0] = word_index; tlast = final_word.
// The 64th byte of a block starts a compression that holds s_axis_tready low
// until it ends. Rounds 0 to 47 step through S_RD0, S_RD1, S_RD9, S_RD14 and
// S_WB: the schedule memory has one read port, so w[t-16], w[t-15], w[t-7] and
// w[t-2] come out one per cycle, the expanded word is written back and the next
// round's word is fetched. Rounds 48 to 63 use S_RD0 and S_WB only, with S_RINIT
// to load the working variables and S_FIN to add them into the chain. An end
// request pads the block one word at a time, runs one or two compressions and
// emits eight digest words on m_axis, one per cycle while m_axis_tready is high.
// A stall holds the current word; no input is taken until the last word leaves.
// Reset restores the initial hash value and clears the byte count; the schedule
// memory is not cleared.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic [1:0]  s_axis_tuser,  // byte_present, message_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // digest_word
	output logic [2:0]  m_axis_tuser,  // word_index
	output logic        m_axis_tlast   // final_word
);
	import sha_pkg::*;

	typedef enum logic [3:0] {
		S_IN, S_PADW, S_LEN, S_RINIT, S_RD0, S_RD1, S_RD9, S_RD14, S_WB,
		S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [COUNT_W-1:0] count_q;
	word_t acc_q;          // word being assembled
	logic [3:0] padw_q;    // next word to zero
	logic two_q;           // length block still to come
	logic end_q;           // compressing for message end
	logic [5:0] rnd_q;
	word_t w0_q, w1_q, w9_q;
	logic [2:0] oidx_q;

	wmem_req_t req;
	word_t rdata;
	logic start, step, finish, reinit;
	word_t chain_word;

	sha_wmem u_wmem (.clk(clk), .req(req), .rdata(rdata));

	sha_round u_round (
		.clk(clk), .arst_n(arst_n), .start(start), .step(step), .rnd(rnd_q),
		.w(rdata), .finish(finish), .reinit(reinit), .rd_idx(oidx_q),
		.rd_word(chain_word)
	);

	logic       in_acc;
	logic [5:0] pos;
	logic [1:0] bsel;
	word_t      pb_word;  // acc with byte placed
	word_t      pad_word;
	logic [63:0] bits;
	logic [3:0]  slot;

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign pos = count_q[5:0];
	assign bsel = pos[1:0];
	assign bits = {count_q, 3'b000};
	assign slot = rnd_q[3:0];

	function automatic word_t place(input word_t a, input logic [1:0] b, input logic [7:0] d);
		word_t r;
		r = a;
		case (b)
			2'd0: r = {d, 24'h0};
			2'd1: r[23:16] = d;
			2'd2: r[15:8] = d;
			default: r[7:0] = d;
		endcase
		return r;
	endfunction

	assign pb_word = place(acc_q, bsel, s_axis_tdata);
	assign pad_word = place(acc_q, bsel, PAD_BYTE);

	// expanded word from w[t-16], w[t-15], w[t-7], w[t-2]
	word_t wnew;
	assign wnew = w0_q + sig0(w1_q) + w9_q + sig1(rdata);

	always_comb begin
		req = '0;
		start = 1'b0;
		step = 1'b0;
		finish = 1'b0;
		reinit = 1'b0;
		req.raddr = slot;
		unique case (state_q)
			S_IN: begin
				if (in_acc && s_axis_tuser[0]) begin
					req.we = 1'b1;
					req.waddr = pos[5:2];
					req.wdata = pb_word;
				end
			end
			S_PADW: begin
				// first word carries the pad byte, acc is zero after it
				req.we = 1'b1;
				req.waddr = padw_q;
				req.wdata = acc_q;
			end
			S_LEN: begin
				req.we = 1'b1;
				req.waddr = padw_q;
				req.wdata = padw_q[0] ? bits[31:0] : bits[63:32];
			end
			S_RINIT: start = 1'b1;
			S_RD0: begin
				step = 1'b1;
				req.raddr = slot + 4'd1;
			end
			S_RD1: req.raddr = slot + 4'd9;
			S_RD9: req.raddr = slot + 4'd14;
			S_RD14: begin
				req.we = 1'b1;
				req.waddr = slot;
				req.wdata = wnew;
			end
			S_WB: ;
			S_FIN: begin
				finish = (rnd_q == 6'd0);
			end
			S_OUT: reinit = m_axis_tready && (oidx_q == 3'd7);
			default: ;
		endcase
	end

	// reads: S_WB issues read of next slot, S_RD0 consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
			count_q <= '0;
			padw_q <= '0;
			two_q <= 1'b0;
			end_q <= 1'b0;
			rnd_q <= '0;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				S_IN: begin
					if (in_acc) begin
						if (s_axis_tuser[0]) begin
							count_q <= count_q + COUNT_W'(1);
							acc_q <= pb_word;
							if (pos == 6'd63) begin
								state_q <= S_RINIT;
								rnd_q <= '0;
								end_q <= s_axis_tuser[1];
								// end with full block: pad starts next block
							end else if (s_axis_tuser[1]) begin
								state_q <= S_FIN;
								end_q <= 1'b1;
								rnd_q <= '1;
							end
						end else if (s_axis_tuser[1]) begin
							state_q <= S_FIN;
							end_q <= 1'b1;
							rnd_q <= '1;
						end
					end
				end
				S_PADW: begin
					padw_q <= padw_q + 4'd1;
					acc_q <= '0;
					if (padw_q == 4'd13) begin
						state_q <= two_q ? S_RINIT : S_LEN;
						rnd_q <= '0;
					end else if (padw_q == 4'd15) begin
						state_q <= S_RINIT;
						rnd_q <= '0;
					end
				end
				S_LEN: begin
					// stays at 15 to mark the length block as written
					if (padw_q == 4'd15) begin
						state_q <= S_RINIT;
						rnd_q <= '0;
					end else begin
						padw_q <= padw_q + 4'd1;
					end
				end
				S_RINIT: state_q <= S_RD0;
				S_RD0: begin
					if (rnd_q >= 6'd48) begin
						rnd_q <= rnd_q + 6'd1;
						state_q <= (rnd_q == 6'd63) ? S_FIN : S_WB;
					end else begin
						w0_q <= rdata;
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD9;
				S_RD9: state_q <= S_RD14;
				S_RD14: begin
					rnd_q <= rnd_q + 6'd1;
					state_q <= S_WB;
				end
				S_WB: state_q <= S_RD0;
				S_FIN: begin
					if (rnd_q == 6'd0) begin
						// block finished (rnd wrapped); chain updated this cycle
						if (!end_q) begin
							state_q <= S_IN;
						end else if (two_q) begin
							two_q <= 1'b0;
							padw_q <= '0;
							state_q <= S_PADW;
						end else if (count_q[5:0] == 6'd0 && padw_q != 4'd15) begin
							// full block just done at message end: whole pad block
							acc_q <= '0;
							padw_q <= 4'd0;
							state_q <= S_FIN;
							rnd_q <= '1;
							two_q <= 1'b0;
						end else begin
							state_q <= S_OUT;
							oidx_q <= '0;
						end
					end else begin
						// start of padding for this message
						padw_q <= pos[5:2];
						acc_q <= pad_word;
						two_q <= (pos >= LEN_POS);
						state_q <= S_PADW;
						rnd_q <= '0;
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= S_IN;
							count_q <= '0;
							end_q <= 1'b0;
							padw_q <= '0;
						end
					end
				end
				default: state_q <= S_IN;
			endcase
			if (state_q == S_RD1) w1_q <= rdata;
			if (state_q == S_RD9) w9_q <= rdata;
		end
	end

	assign s_axis_tready = (state_q == S_IN);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = chain_word;
	assign m_axis_tuser = oidx_q;
	assign m_axis_tlast = (oidx_q == 3'd7);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input open while emitting");
	a_out_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid &&
		m_axis_tuser == $past(m_axis_tuser) + 3'd1) else $error("digest order");
	a_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> count_q == '0)
		else $error("count not cleared");
endmodule

// ----- tb/sha256_message_hasher_test.sv -----
`timescale 1ns / 1ps
module sha256_message_hasher_test;
	import sha_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned LONG_HOLD = 3000;

	typedef struct {
		word_t    word;
		bit [2:0] index;
		bit       last;
	} digest_beat_t;

	class digest_scoreboard;
		word_t        chain [8];
		word_t        blk [16];
		bit [60:0]    byte_count;
		digest_beat_t pending [$];
		int unsigned  errors;
		int unsigned  words_seen;

		function void clear_state();
			for (int i = 0; i < 8; i++)
				chain[i] = INIT_HASH[i];
			byte_count = '0;
		endfunction

		function word_t ror(word_t x, int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			word_t w [64];
			word_t v [8];
			word_t t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = blk[i];
			for (int i = 16; i < 64; i++)
				w[i] = w[i-16] + w[i-7]
					+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
					+ (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
			v = chain;
			for (int i = 0; i < 64; i++) begin
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] += v[i];
		endfunction

		// big-endian placement; the first byte of a word overwrites all of it
		function void place(bit [5:0] pos, bit [7:0] b);
			if (pos[1:0] == 2'd0)
				blk[pos[5:2]] = {b, 24'd0};
			else
				blk[pos[5:2]][8*(3-pos[1:0]) +: 8] = b;
		endfunction

		function void note_request(bit [7:0] b, bit present, bit last);
			bit [5:0]  pos;
			bit [63:0] bits;
			if (present) begin
				pos = byte_count[5:0];
				place(pos, b);
				byte_count++;
				if (pos == 6'd63)
					compress();
			end
			if (!last)
				return;
			pos = byte_count[5:0];
			place(pos, PAD_BYTE);
			for (int i = pos[5:2] + 1; i < 16; i++)
				blk[i] = '0;
			if (pos >= LEN_POS) begin
				compress();
				for (int i = 0; i < 16; i++)
					blk[i] = '0;
			end
			bits = {byte_count, 3'd0};
			blk[14] = bits[63:32];
			blk[15] = bits[31:0];
			compress();
			for (int i = 0; i < 8; i++)
				pending.push_back('{chain[i], 3'(i), i == 7});
			clear_state();
		endfunction

		function void check_result(word_t word, bit [2:0] index, bit last);
			digest_beat_t e;
			words_seen++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected digest word %h index %0d", $time, word, index);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (word !== e.word) begin
				$display("%0t: digest word: expected %h, actual %h", $time, e.word, word);
				errors++;
			end
			if (index !== e.index) begin
				$display("%0t: word index: expected %0d, actual %0d", $time, e.index, index);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last flag: expected %0d, actual %0d", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	digest_scoreboard sb;
	int unsigned cycles;
	int unsigned items_sent;
	int unsigned messages_sent;
	bit          quiet;
	bit          hold_request;

	sha256_message_hasher u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int unsigned n;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else if (!quiet && $urandom_range(3) == 0) begin
				n = $urandom_range(12, 1);
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = $urandom_range(10, 1);
				m_axis_tready <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_item(bit [7:0] b, bit present, bit last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= {last, present};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(b, present, last);
		if (present || last)
			items_sent++;
		if (!quiet && $urandom_range(4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
	endtask

	// end flag rides on the last byte or on a separate empty request
	task automatic send_message(int unsigned len, bit [7:0] fill, bit use_fill);
		bit joined;
		joined = (len > 0) && $urandom_range(1);
		for (int unsigned i = 0; i < len; i++) begin
			if (!quiet && $urandom_range(9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(use_fill ? fill : 8'($urandom), 1'b1, joined && i == len - 1);
		end
		if (!joined)
			send_item(8'($urandom), 1'b0, 1'b1);
		messages_sent++;
	endtask

	initial begin
		int unsigned len;
		sb = new();
		sb.clear_state();
		items_sent = 0;
		messages_sent = 0;
		quiet = 1'b0;
		hold_request = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, idle requests, byte extremes, "abc"
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b1);
		send_message(4, 8'haa, 1'b1);
		send_message(3, 8'h55, 1'b1);

		// back-pressure: output held off while the next messages wait at the input
		hold_request = 1'b1;
		send_message(2, 8'h00, 1'b0);
		send_message(1, 8'h00, 1'b0);

		// padding boundaries: one block, length spills, exact block
		send_message(55, 8'h00, 1'b0);
		send_message(56, 8'h00, 1'b0);
		while (items_sent < 180) begin
			if (items_sent > 140)
				quiet = 1'b1;
			case ($urandom_range(9))
				0: len = $urandom_range(70, 50);
				1: len = 64;
				default: len = $urandom_range(8);
			endcase
			send_message(len, 8'h00, 1'b0);
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);

		$display("%0d messages in %0d requests, %0d digest words checked",
			messages_sent, items_sent, sb.words_seen);
		$display("covered empty, single-byte, padding boundary and multi-block messages");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
